// ----- hw/rtl/kres_pkg.sv -----
// ----------------------------------------------------------------------------
// kres_pkg: shared types and constants of the range estimator
// Item layouts, lane and steering control groups, fixed-point widths and
// register codes used by the core, lane, steering and bench files.
// ----------------------------------------------------------------------------
package kres_pkg;

  // Field widths of the fixed-point formats.
  localparam int DistW = 16;  // unsigned Q4.12 distance
  localparam int VarW  = 32;  // unsigned Q16.16 variance
  localparam int NoiseW = 16; // unsigned Q0.16 noise settings
  localparam int CmdW  = 32;  // signed Q.12 commands
  localparam int FracW = 16;  // fraction bits of a gain

  // Gain is Q0.16 in 0..65536, so the division yields 17 quotient bits.
  localparam int GainW  = FracW + 1;
  localparam int DenW   = VarW + 1;
  localparam int RemW   = DenW;
  localparam int TrialW = DenW + 1;
  localparam int DiffW  = DistW + 1;
  localparam int AccEW  = DiffW + GainW;
  localparam int AccVW  = VarW + FracW;
  localparam int AdjW   = AccEW - FracW;
  localparam int NxW    = AdjW + 1;
  localparam int RoundHalf = 32768;

  // Lane sequencer: division steps, last accumulate, rounding, write-back.
  localparam int StepRound = GainW + 1;
  localparam int StepWrite = GainW + 2;
  localparam int CntW      = $clog2(StepWrite + 1);

  // Steering arithmetic widths.
  localparam int WallW  = DiffW + 9;
  localparam int FrontW = DiffW + 6;
  localparam int SpeedW = DistW + 2;
  localparam logic [DistW-1:0] OneMeterQ12 = 16'd4096;

  // Configuration register indexes and reset values.
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgProcessVar = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMeasVar    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgWallTarget = 2'd2;
  localparam logic [NoiseW-1:0] ProcessVarRst = 16'd1311;
  localparam logic [NoiseW-1:0] MeasVarRst    = 16'd655;
  localparam logic [DistW-1:0]  WallTargetRst = 16'd819;

  // Input command codes.
  localparam logic CmdTick = 1'b0;
  localparam logic CmdMeas = 1'b1;

  typedef struct packed {
    logic             cmd;
    logic [DistW-1:0] dist_left;
    logic [DistW-1:0] dist_front;
    logic [DistW-1:0] dist_right;
  } kres_in_t;

  typedef struct packed {
    logic        [DistW-1:0] est_left;
    logic        [DistW-1:0] est_front;
    logic        [DistW-1:0] est_right;
    logic signed [CmdW-1:0]  linear_speed;
    logic signed [CmdW-1:0]  turn_rate;
  } kres_out_t;

  typedef struct packed {
    logic             tick;
    logic             correct;
    logic [DistW-1:0] reading;
  } kres_lane_ctrl_t;

  typedef struct packed {
    logic busy;
  } kres_lane_stat_t;

  typedef struct packed {
    logic             load;
    logic [DistW-1:0] est_left;
    logic [DistW-1:0] est_front;
    logic [DistW-1:0] est_right;
    logic [DistW-1:0] wall_target;
  } kres_steer_ctrl_t;

  typedef struct packed {
    logic done;
  } kres_steer_stat_t;

endpackage

// ----- hw/rtl/kres_stream_if.sv -----
// ----------------------------------------------------------------------------
// kres_stream_if: valid/ready stream channel
// Carries one item per transfer; the payload type is set per instance.
// ----------------------------------------------------------------------------
interface kres_stream_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

// ----- hw/rtl/kalman_range_estimator_steering_core.sv -----
// ----------------------------------------------------------------------------
// kalman_range_estimator_steering_core: range filter with steering commands
// Measurement: the lanes run in parallel; the bit-serial gain divider and
//   its accumulators run while the core waits for every lane to finish.
// Tick: the result passes the steering stages into the output register;
//   next input taken then, or later while the previous result still waits in it.
// Reset (rst_ni low, asynchronous): configuration to reset values, estimates
//   and variances to zero, no result pending.
// ----------------------------------------------------------------------------
module kalman_range_estimator_steering_core
  import kres_pkg::*;
#(
  parameter int CHANNELS = 3
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  kres_stream_if.sink         in_i,
  kres_stream_if.source       out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [NoiseW-1:0]   cfg_data_i
);

  localparam int ViewLanes = 3;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CORR  = 2'd1;
  localparam logic [1:0] S_STEER = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [NoiseW-1:0]   process_var_q;
  logic [NoiseW-1:0]   meas_var_q;
  logic [DistW-1:0]    wall_target_q;
  logic                out_vld_q;
  kres_out_t           out_data_q;

  logic                in_xfer;
  logic                tick_go;
  logic                meas_go;
  logic                out_load;
  logic [DistW-1:0]    reading_w [ViewLanes];
  logic [DistW-1:0]    est_view  [ViewLanes];
  logic [DistW-1:0]    lane_est  [CHANNELS];
  kres_lane_ctrl_t     lane_ctrl [CHANNELS];
  kres_lane_stat_t     lane_stat [CHANNELS];
  logic [CHANNELS-1:0] lane_busy;
  kres_steer_ctrl_t    steer_ctrl;
  kres_steer_stat_t    steer_stat;
  kres_out_t           steer_item;

  // Input transfer decode.
  assign in_i.ready = (state_q == S_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign tick_go    = in_xfer && (in_i.data.cmd == CmdTick);
  assign meas_go    = in_xfer && (in_i.data.cmd == CmdMeas);

  assign reading_w[0] = in_i.data.dist_left;
  assign reading_w[1] = in_i.data.dist_front;
  assign reading_w[2] = in_i.data.dist_right;

  // Filter lanes; lanes past the three sensors see a reading of zero.
  for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
    if (i < ViewLanes) begin : g_rd
      assign lane_ctrl[i].reading = reading_w[i];
    end else begin : g_zero
      assign lane_ctrl[i].reading = '0;
    end
    assign lane_ctrl[i].tick    = tick_go;
    assign lane_ctrl[i].correct = meas_go;
    assign lane_busy[i]         = lane_stat[i].busy;

    kres_lane u_lane (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (lane_ctrl[i]),
      .process_var_i (process_var_q),
      .meas_var_i    (meas_var_q),
      .est_o         (lane_est[i]),
      .stat_o        (lane_stat[i])
    );
  end

  // Output view of the lanes; a missing lane reads as zero.
  for (genvar i = 0; i < ViewLanes; i++) begin : g_view
    if (i < CHANNELS) begin : g_have
      assign est_view[i] = lane_est[i];
    end else begin : g_none
      assign est_view[i] = '0;
    end
  end

  // Steering commands from the estimates at the tick.
  assign steer_ctrl.load        = tick_go;
  assign steer_ctrl.est_left    = est_view[0];
  assign steer_ctrl.est_front   = est_view[1];
  assign steer_ctrl.est_right   = est_view[2];
  assign steer_ctrl.wall_target = wall_target_q;

  kres_steer u_steer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (steer_ctrl),
    .item_o (steer_item),
    .stat_o (steer_stat)
  );

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (tick_go) begin
          state_d = S_STEER;
        end else if (meas_go) begin
          state_d = S_CORR;
        end
      end
      S_CORR: begin
        if (lane_busy == '0) begin
          state_d = S_IDLE;
        end
      end
      S_STEER: begin
        if (steer_stat.done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_vld_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers and configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      out_vld_q     <= 1'b0;
      process_var_q <= ProcessVarRst;
      meas_var_q    <= MeasVarRst;
      wall_target_q <= WallTargetRst;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_load || (out_vld_q && !out_o.ready);
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgProcessVar: process_var_q <= cfg_data_i;
          CfgMeasVar:    meas_var_q    <= cfg_data_i;
          CfgWallTarget: wall_target_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  // Output register, which parts the result from the sink.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= steer_item;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_data_q;

  // A new item is only taken once every lane has finished.
  a_ready_lanes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> (lane_busy == '0))
    else $error("input ready while a lane is still correcting");

  // Lanes only work during a correction.
  a_busy_in_corr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lane_busy != '0) |-> (state_q == S_CORR))
    else $error("lane busy outside correction");

  // A tick transfer starts the steering pipeline.
  a_tick_steer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_go |=> (state_q == S_STEER) ##1 steer_stat.done)
    else $error("tick did not produce a steering result");

endmodule

// ----- hw/rtl/kres_lane.sv -----
// ----------------------------------------------------------------------------
// kres_lane: one scalar Kalman filter lane
// Holds estimate and variance. A correction runs a radix-2 restoring divider
// that produces the gain one bit per cycle, MSB first, while two Horner
// accumulators fold each gain bit into gain*diff and gain*variance.
// ----------------------------------------------------------------------------
module kres_lane
  import kres_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kres_lane_ctrl_t     ctrl_i,
  input  logic [NoiseW-1:0]   process_var_i,
  input  logic [NoiseW-1:0]   meas_var_i,
  output logic [DistW-1:0]    est_o,
  output kres_lane_stat_t     stat_o
);

  logic                     busy_q;
  logic [CntW-1:0]          cnt_q;
  logic [DistW-1:0]         est_q;
  logic [VarW-1:0]          var_q;
  logic [RemW-1:0]          rem_q;
  logic [DenW-1:0]          den_q;
  logic                     qbit_q;
  logic signed [DiffW-1:0]  diff_q;
  logic signed [AccEW-1:0]  acc_e_q;
  logic [AccVW-1:0]         acc_v_q;
  logic signed [AdjW-1:0]   adj_q;

  logic [DenW-1:0]          den;
  logic                     start;
  logic signed [DiffW-1:0]  diff;
  logic [TrialW-1:0]        trial;
  logic                     q_bit;
  logic [TrialW-1:0]        rem_next;
  logic signed [AccEW-1:0]  e_add;
  logic [AccVW-1:0]         v_add;
  logic signed [AccEW-1:0]  rounded;
  logic [DenW-1:0]          var_sum;
  logic [VarW-1:0]          var_tick;
  logic [AccVW-1:0]         var_scaled;
  logic signed [NxW-1:0]    nx;
  logic [DistW-1:0]         est_upd;
  logic                     div_step;
  logic                     acc_step;

  // Operand setup and the start condition; a zero denominator leaves the lane.
  always_comb begin
    den   = {1'b0, var_q} + DenW'(meas_var_i);
    diff  = $signed({1'b0, ctrl_i.reading}) - $signed({1'b0, est_q});
    start = ctrl_i.correct && (den != '0);
  end

  // One restoring division step; the first step compares without a shift.
  always_comb begin
    trial    = (cnt_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
    q_bit    = trial >= {1'b0, den_q};
    rem_next = q_bit ? (trial - {1'b0, den_q}) : trial;
    div_step = busy_q && (cnt_q < CntW'(GainW));
    acc_step = busy_q && (cnt_q != '0) && (cnt_q <= CntW'(GainW));
  end

  // Horner accumulation of the previous quotient bit.
  always_comb begin
    e_add = qbit_q ? AccEW'(diff_q) : '0;
    v_add = qbit_q ? AccVW'(var_q) : '0;
  end

  // Rounding and write-back values.
  always_comb begin
    rounded    = acc_e_q + AccEW'(RoundHalf);
    var_scaled = {var_q, FracW'(RoundHalf)} - acc_v_q;
    nx         = NxW'($signed({1'b0, est_q})) + NxW'(adj_q);
    if (nx[NxW-1]) begin
      est_upd = '0;
    end else if (|nx[NxW-2:DistW]) begin
      est_upd = '1;
    end else begin
      est_upd = nx[DistW-1:0];
    end
    var_sum  = {1'b0, var_q} + DenW'(process_var_i);
    var_tick = var_sum[DenW-1] ? '1 : var_sum[VarW-1:0];
  end

  // Lane state and sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      est_q  <= '0;
      var_q  <= '0;
    end else begin
      if (ctrl_i.tick) begin
        var_q <= var_tick;
      end
      if (start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(StepRound)) begin
          var_q <= var_scaled[AccVW-1:FracW];
        end
        if (cnt_q == CntW'(StepWrite)) begin
          est_q  <= est_upd;
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Divider and accumulator datapath.
  always_ff @(posedge clk_i) begin
    if (start) begin
      rem_q   <= {1'b0, var_q};
      den_q   <= den;
      diff_q  <= diff;
      acc_e_q <= '0;
      acc_v_q <= '0;
    end else begin
      if (div_step) begin
        rem_q  <= rem_next[RemW-1:0];
        qbit_q <= q_bit;
      end
      if (acc_step) begin
        acc_e_q <= (acc_e_q <<< 1) + e_add;
        acc_v_q <= (acc_v_q << 1) + v_add;
      end
      if (busy_q && (cnt_q == CntW'(StepRound))) begin
        adj_q <= $signed(rounded[AccEW-1:FracW]);
      end
    end
  end

  assign est_o       = est_q;
  assign stat_o.busy = busy_q;

endmodule

// ----- hw/rtl/kres_steer.sv -----
// ----------------------------------------------------------------------------
// kres_steer: steering command generator
// Two-stage pipeline: constant multiplies by shift and add, then the final
// turn-rate sum. The finished result item holds until the next load.
// ----------------------------------------------------------------------------
module kres_steer
  import kres_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kres_steer_ctrl_t  ctrl_i,
  output kres_out_t         item_o,
  output kres_steer_stat_t  stat_o
);

  logic                     s1_vld_q;
  logic                     done_q;
  logic signed [WallW-1:0]  wall_q;
  logic signed [FrontW-1:0] front_q;
  logic [SpeedW-1:0]        speed_q;
  logic [DistW-1:0]         l_q;
  logic [DistW-1:0]         f_q;
  logic [DistW-1:0]         r_q;
  kres_out_t                item_q;

  logic signed [DiffW-1:0]  dl;
  logic signed [DiffW-1:0]  df;
  logic signed [WallW-1:0]  dl_x;
  logic signed [FrontW-1:0] df_x;
  logic signed [WallW-1:0]  wall;
  logic signed [FrontW-1:0] front;
  logic [SpeedW-1:0]        f_x;
  logic [SpeedW-1:0]        speed;

  // Wall error times 400 (256+128+16), front error times 50 (32+16+2),
  // and speed as three times the front estimate.
  always_comb begin
    dl    = $signed({1'b0, ctrl_i.est_left}) - $signed({1'b0, ctrl_i.wall_target});
    df    = $signed({1'b0, ctrl_i.est_front}) - $signed({1'b0, OneMeterQ12});
    dl_x  = WallW'(dl);
    df_x  = FrontW'(df);
    wall  = (dl_x <<< 8) + (dl_x <<< 7) + (dl_x <<< 4);
    front = (df_x <<< 5) + (df_x <<< 4) + (df_x <<< 1);
    f_x   = SpeedW'(ctrl_i.est_front);
    speed = (f_x << 1) + f_x;
  end

  // Stage valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      s1_vld_q <= ctrl_i.load;
      done_q   <= s1_vld_q;
    end
  end

  // Product stage and sum stage.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      wall_q  <= wall;
      front_q <= front;
      speed_q <= speed;
      l_q     <= ctrl_i.est_left;
      f_q     <= ctrl_i.est_front;
      r_q     <= ctrl_i.est_right;
    end
    if (s1_vld_q) begin
      item_q.est_left     <= l_q;
      item_q.est_front    <= f_q;
      item_q.est_right    <= r_q;
      item_q.linear_speed <= $signed(CmdW'(speed_q));
      item_q.turn_rate    <= CmdW'(wall_q) + CmdW'(front_q);
    end
  end

  assign item_o      = item_q;
  assign stat_o.done = done_q;

endmodule

// ----- tb/tb_kalman_range_estimator_steering_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kalman_range_estimator_steering_core: self-checking range filter bench
// A queue-fed driver offers tick and measurement items. A monitor predicts
// every steering result with its own three-lane filter model and checks each
// output transfer field by field. The noise and wall settings are changed
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_kalman_range_estimator_steering_core;
  import kres_pkg::*;

  localparam int NumLanes      = 3;
  localparam int SettleCycles  = 40;     // idle margin after the last result so a final measurement can finish
  localparam int LongHold      = 300;
  localparam int RandPhaseLen  = 85;
  localparam int SoakTicks     = 40;     // full-scale ticks that keep growing the variances
  localparam int MaxPrinted    = 50;
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;
  localparam logic [DistW-1:0]   FullDist  = 16'hFFFF;
  localparam logic [DistW-1:0]   NearDist  = 16'd1024;
  localparam logic [DistW-1:0]   FarDist   = 16'd12288;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [NoiseW-1:0]  cfg_data_i;

  kres_stream_if #(.T(kres_in_t))  in_if ();
  kres_stream_if #(.T(kres_out_t)) out_if ();

  kalman_range_estimator_steering_core #(
    .CHANNELS(NumLanes)
  ) u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_if),
    .out_o     (out_if),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // Filter state and settings as the block should hold them.
  logic [DistW-1:0]  lane_est [NumLanes];
  logic [VarW-1:0]   lane_var [NumLanes];
  logic [NoiseW-1:0] process_var_q;
  logic [NoiseW-1:0] meas_var_q;
  logic [DistW-1:0]  wall_target_q;

  kres_in_t  pending_readings [$];
  kres_out_t expected_steer [$];

  logic in_taken;
  logic idle_on;
  int   src_gap;
  int   sink_hold;
  int   hold_requests;
  int   hold_served;
  int   err_count;
  int   n_ticks;
  int   n_meas;
  int   n_checked;
  int   n_cfg_writes;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #12000000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(string what, longint got, longint want);
    if (err_count < MaxPrinted) begin
      $display("[%0t] Mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    end
    err_count++;
  endtask

  // Measurement update of one lane: gain, estimate pull and variance shrink.
  function automatic void correct_lane(int lane, logic [DistW-1:0] reading);
    longint unsigned v;
    longint unsigned den;
    longint unsigned gain;
    longint unsigned shrunk;
    longint diff;
    longint prod;
    longint adj;
    longint nx;
    v   = lane_var[lane];
    den = v + meas_var_q;
    // Zero noise on a zero variance leaves the lane alone.
    if (den == 0) return;
    gain = (v << FracW) / den;
    diff = longint'(reading) - longint'(lane_est[lane]);
    prod = longint'(gain) * diff;
    adj  = (prod + RoundHalf) >>> FracW;
    nx   = longint'(lane_est[lane]) + adj;
    if (nx < 0) nx = 0;
    if (nx > longint'(FullDist)) nx = longint'(FullDist);
    lane_est[lane] = DistW'(nx);
    shrunk = (v * ((64'd1 << FracW) - gain) + RoundHalf) >> FracW;
    lane_var[lane] = VarW'(shrunk);
  endfunction

  // Advances the filter by one accepted item and queues the steering result
  // that a tick produces.
  function automatic void kalman_step(kres_in_t item);
    logic [DistW-1:0] reading [NumLanes];
    logic [VarW:0]    grown;
    kres_out_t        want;
    longint           turn;
    reading[0] = item.dist_left;
    reading[1] = item.dist_front;
    reading[2] = item.dist_right;
    if (item.cmd == CmdMeas) begin
      for (int i = 0; i < NumLanes; i++) correct_lane(i, reading[i]);
      n_meas++;
    end else begin
      for (int i = 0; i < NumLanes; i++) begin
        grown = {1'b0, lane_var[i]} + process_var_q;
        lane_var[i] = grown[VarW] ? '1 : grown[VarW-1:0];
      end
      turn = 400 * (longint'(lane_est[0]) - longint'(wall_target_q))
           + 50 * (longint'(lane_est[1]) - longint'(OneMeterQ12));
      want.est_left     = lane_est[0];
      want.est_front    = lane_est[1];
      want.est_right    = lane_est[2];
      want.linear_speed = CmdW'(3 * longint'(lane_est[1]));
      want.turn_rate    = CmdW'(turn);
      expected_steer.push_back(want);
      n_ticks++;
    end
  endfunction

  // Driver: offers the next queued item, with random gaps between items while idle_on is set.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_if.valid || in_taken)) begin
      if (src_gap > 0) begin
        src_gap--;
        in_if.valid <= 1'b0;
      end else if (pending_readings.size() > 0) begin
        in_if.data  <= pending_readings.pop_front();
        in_if.valid <= 1'b1;
        if (idle_on && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 5);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result side: random stall bursts while idle_on is set, plus the requested long hold.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        sink_hold   = LongHold - 1;
        out_if.ready <= 1'b0;
      end else if (sink_hold > 0) begin
        sink_hold--;
        out_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        sink_hold = $urandom_range(0, 4);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Monitor: checks output transfers, then feeds input transfers to the model.
  always @(posedge clk_i) begin
    kres_out_t got;
    kres_out_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        got = out_if.data;
        if (expected_steer.size() == 0) begin
          report_mismatch("result with nothing expected", got.est_left, 0);
        end else begin
          want = expected_steer.pop_front();
          if (got.est_left !== want.est_left)
            report_mismatch("est_left", got.est_left, want.est_left);
          if (got.est_front !== want.est_front)
            report_mismatch("est_front", got.est_front, want.est_front);
          if (got.est_right !== want.est_right)
            report_mismatch("est_right", got.est_right, want.est_right);
          if (got.linear_speed !== want.linear_speed)
            report_mismatch("linear_speed", got.linear_speed, want.linear_speed);
          if (got.turn_rate !== want.turn_rate)
            report_mismatch("turn_rate", got.turn_rate, want.turn_rate);
          n_checked++;
        end
      end
      if (in_if.valid && in_if.ready) kalman_step(in_if.data);
      in_taken <= in_if.valid && in_if.ready;
    end
  end

  function automatic void queue_item(logic cmd, logic [DistW-1:0] left,
                                     logic [DistW-1:0] front, logic [DistW-1:0] right);
    kres_in_t item;
    item.cmd        = cmd;
    item.dist_left  = left;
    item.dist_front = front;
    item.dist_right = right;
    pending_readings.push_back(item);
  endfunction

  // Mostly plausible ranges, with both ends and full-width noise mixed in.
  function automatic logic [DistW-1:0] rand_dist();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return FullDist;
      2, 3:    return DistW'($urandom);
      default: return DistW'($urandom_range(NearDist, FarDist));
    endcase
  endfunction

  function automatic void queue_random(int count);
    for (int n = 0; n < count; n++) begin
      queue_item(($urandom_range(0, 2) == 0) ? CmdTick : CmdMeas,
                 rand_dist(), rand_dist(), rand_dist());
    end
  endfunction

  // Waits until every item is taken and every result has arrived.
  task automatic wait_quiet();
    do @(posedge clk_i);
    while (pending_readings.size() != 0 || in_if.valid || expected_steer.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [NoiseW-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgProcessVar: process_var_q = value;
      CfgMeasVar:    meas_var_q    = value;
      CfgWallTarget: wall_target_q = value;
      default: ;  // unmapped index, the block ignores it
    endcase
    n_cfg_writes++;
  endtask

  task automatic apply_settings(logic [NoiseW-1:0] pv, logic [NoiseW-1:0] mv,
                                logic [DistW-1:0] wt);
    wait_quiet();
    write_reg(CfgProcessVar, pv);
    write_reg(CfgMeasVar, mv);
    write_reg(CfgWallTarget, wt);
  endtask

  // Stimulus sequence.
  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_data_i   = '0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    in_taken      = 1'b0;
    idle_on       = 1'b1;
    src_gap       = 0;
    sink_hold     = 0;
    hold_requests = 0;
    hold_served   = 0;
    err_count     = 0;
    n_ticks       = 0;
    n_meas        = 0;
    n_checked     = 0;
    n_cfg_writes  = 0;
    process_var_q = ProcessVarRst;
    meas_var_q    = MeasVarRst;
    wall_target_q = WallTargetRst;
    for (int i = 0; i < NumLanes; i++) begin
      lane_est[i] = '0;
      lane_var[i] = '0;
    end
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // Zero sensor noise: with zero variance the lanes must stay put, and after
    // a tick the gain is full so the estimates jump onto the readings.
    write_reg(CfgUnused, 16'hFFFF);
    write_reg(CfgMeasVar, '0);
    queue_item(CmdMeas, FullDist, FullDist, FullDist);
    queue_item(CmdTick, '0, '0, '0);
    queue_item(CmdMeas, FullDist, '0, 16'h8000);
    queue_item(CmdTick, FullDist, FullDist, FullDist);

    // Reset settings: extreme and alternating readings, back-to-back ticks.
    apply_settings(ProcessVarRst, MeasVarRst, WallTargetRst);
    queue_item(CmdMeas, FullDist, FullDist, FullDist);
    queue_item(CmdTick, '0, '0, '0);
    queue_item(CmdMeas, '0, '0, '0);
    queue_item(CmdTick, FullDist, FullDist, FullDist);
    queue_item(CmdMeas, 16'hAAAA, 16'h5555, 16'hAAAA);
    queue_item(CmdTick, 16'h5555, 16'hAAAA, 16'h5555);
    queue_item(CmdMeas, 16'h5555, 16'hAAAA, 16'h5555);
    queue_item(CmdTick, '0, '0, '0);
    queue_item(CmdTick, '0, '0, '0);
    queue_item(CmdTick, '0, '0, '0);
    queue_item(CmdMeas, OneMeterQ12, OneMeterQ12, OneMeterQ12);
    queue_item(CmdMeas, WallTargetRst, FarDist, NearDist);
    queue_item(CmdTick, '0, '0, '0);

    // Random phases under different settings.
    apply_settings(ProcessVarRst, MeasVarRst, WallTargetRst);
    queue_random(RandPhaseLen);

    apply_settings('0, 16'd1, '0);
    queue_random(RandPhaseLen);

    // Full-scale settings; the result side holds off long enough to back up
    // the input while items keep being offered.
    apply_settings('1, '1, '1);
    hold_requests++;
    queue_random(RandPhaseLen);

    apply_settings(NoiseW'($urandom), NoiseW'($urandom_range(1, 65535)), DistW'($urandom));
    idle_on = 1'b0;
    queue_random(RandPhaseLen);

    apply_settings(NoiseW'($urandom), NoiseW'($urandom_range(1, 65535)), DistW'($urandom));
    idle_on = 1'b1;
    queue_random(RandPhaseLen);

    apply_settings(NoiseW'($urandom), NoiseW'($urandom_range(1, 65535)), DistW'($urandom));
    queue_random(RandPhaseLen);

    // Closing run without idling: ticks at full process noise grow the
    // variances, then a few corrections from there.
    apply_settings('1, NoiseW'($urandom_range(1, 65535)), DistW'($urandom));
    idle_on = 1'b0;
    for (int n = 0; n < SoakTicks; n++) queue_item(CmdTick, '0, '0, '0);
    queue_random(24);

    wait_quiet();
    if (expected_steer.size() != 0)
      report_mismatch("results never delivered", 0, expected_steer.size());
    $display("Run covered %0d ticks and %0d measurements under %0d register writes.",
             n_ticks, n_meas, n_cfg_writes);
    $display("Checked %0d steering results, including zero noise and full-scale settings.",
             n_checked);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
